// ----- rtl/core/slpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpc_pkg
// Shared constants and types for the SLP header classifier.
// ----------------------------------------------------------------------------
package slpc_pkg;

	localparam int unsigned DEF_MAX_PAYLOAD_BYTES = 65535;
	localparam int unsigned DEF_REQUEST_STRINGS   = 5;

	localparam int unsigned CFG_W  = 8;
	localparam int unsigned CFG_IW = 2;
	localparam int unsigned OFS_W  = 17;

	localparam logic [CFG_W-1:0] RST_MIN_V1   = 8'd12;
	localparam logic [CFG_W-1:0] RST_MIN_V2   = 8'd24;
	localparam logic [CFG_W-1:0] RST_LANG_MAX = 8'd8;

	localparam logic [7:0] VER_ONE      = 8'd1;
	localparam logic [7:0] VER_TWO      = 8'd2;
	localparam logic [7:0] FUNC_SRV_REQ = 8'd1;
	localparam logic [7:0] FUNC_V1_MAX  = 8'd10;
	localparam logic [7:0] FUNC_V2_MAX  = 8'd11;

	localparam logic [OFS_W-1:0] V1_HDR_BYTES = 17'd6;
	localparam logic [OFS_W-1:0] V2_HDR_BYTES = 17'd14;

	typedef enum logic [CFG_IW-1:0] {
		CFG_MIN_V1   = 2'd0,
		CFG_MIN_V2   = 2'd1,
		CFG_LANG_MAX = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		SEEN_NONE = 2'd0,
		SEEN_V1   = 2'd1,
		SEEN_V2   = 2'd2
	} seen_t;

	typedef struct packed {
		logic [7:0]       version;
		logic [7:0]       func;
		logic             fail;
		logic [15:0]      lang_len;
		logic [OFS_W-1:0] next_ofs;
		logic             strings_done;
	} slpc_hdr_t;

endpackage

// ----- rtl/core/slp_header_classifier_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slp_header_classifier_top
// Classifies a byte-stream payload as SLP version 1, version 2 or neither.
// ----------------------------------------------------------------------------
// The last word of a payload is captured in the input register when it is
// accepted, and its verdict is loaded into the result register when that
// word leaves the input register. Words are accepted one per cycle, but a
// last word waits in the input register while the result is not yet read.
// Reset clears the packet state and loads the register defaults 12, 24 and 8.
module slp_header_classifier_top import slpc_pkg::*; #(
	parameter int unsigned MAX_PAYLOAD_BYTES = DEF_MAX_PAYLOAD_BYTES,
	parameter int unsigned REQUEST_STRINGS   = DEF_REQUEST_STRINGS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [7:0] data_byte
	input  logic              s_tlast,   // last_byte
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata    // [0] is_match, [2:1] seen_version, [7:3] zero
);

	localparam int unsigned POS_W = $clog2(MAX_PAYLOAD_BYTES + 1);

	logic [CFG_W-1:0] min_v1_q;
	logic [CFG_W-1:0] min_v2_q;
	logic [CFG_W-1:0] lang_max_q;

	logic       in_valid_s1;
	logic [7:0] in_byte_s1;
	logic       in_last_s1;

	logic       out_valid_q;
	logic       out_match_q;
	logic [1:0] out_ver_q;

	logic             out_free;
	logic             take;
	slpc_hdr_t        hdr_nxt;
	logic [POS_W-1:0] pos_nxt;
	logic             is_match;
	logic [1:0]       seen_version;

	assign out_free = !out_valid_q || m_tready;
	assign take     = in_valid_s1 && (!in_last_s1 || out_free);
	assign s_tready = !in_valid_s1 || take;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_ver_q, out_match_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_v1_q   <= RST_MIN_V1;
			min_v2_q   <= RST_MIN_V2;
			lang_max_q <= RST_LANG_MAX;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MIN_V1:   min_v1_q   <= cfg_data;
				CFG_MIN_V2:   min_v2_q   <= cfg_data;
				CFG_LANG_MAX: lang_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_byte_s1 <= s_tdata;
			in_last_s1 <= s_tlast;
		end
	end

	slpc_parser #(
		.MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES),
		.REQUEST_STRINGS(REQUEST_STRINGS)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.data_byte(in_byte_s1),
		.last_byte(in_last_s1),
		.hdr_nxt(hdr_nxt),
		.pos_nxt(pos_nxt)
	);

	slpc_verdict #(
		.POS_W(POS_W)
	) u_verdict (
		.hdr(hdr_nxt),
		.pos(pos_nxt),
		.min_v1(min_v1_q),
		.min_v2(min_v2_q),
		.lang_max(lang_max_q),
		.is_match(is_match),
		.seen_version(seen_version)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= take && in_last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && take && in_last_s1) begin
			out_match_q <= is_match;
			out_ver_q   <= seen_version;
		end
	end

endmodule

// ----- rtl/core/slpc_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpc_parser
// Per-packet header tracker: folds each payload word into the running header
// state and presents the state as it stands after that word.
// ----------------------------------------------------------------------------
module slpc_parser import slpc_pkg::*; #(
	parameter int unsigned MAX_PAYLOAD_BYTES = DEF_MAX_PAYLOAD_BYTES,
	parameter int unsigned REQUEST_STRINGS   = DEF_REQUEST_STRINGS,
	localparam int unsigned POS_W = $clog2(MAX_PAYLOAD_BYTES + 1),
	localparam int unsigned CNT_W = $clog2(REQUEST_STRINGS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [7:0]       data_byte,
	input  logic             last_byte,
	output slpc_hdr_t        hdr_nxt,
	output logic [POS_W-1:0] pos_nxt
);

	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PAYLOAD_BYTES);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(REQUEST_STRINGS);

	logic [POS_W-1:0] pos_q;
	logic [7:0]       version_q;
	logic [7:0]       func_q;
	logic             fail_q;
	logic [15:0]      lang_len_q;
	logic [OFS_W-1:0] next_ofs_q;
	logic [CNT_W-1:0] count_q;
	logic [7:0]       len_hi_q;

	logic [7:0]       version_n;
	logic [7:0]       func_n;
	logic             fail_n;
	logic [15:0]      lang_len_n;
	logic [OFS_W-1:0] next_ofs_n;
	logic [CNT_W-1:0] count_n;
	logic [7:0]       len_hi_n;
	logic [OFS_W-1:0] pos_ext;

	assign pos_ext = OFS_W'(pos_q);

	always_comb begin
		pos_nxt    = pos_q;
		version_n  = version_q;
		func_n     = func_q;
		fail_n     = fail_q;
		lang_len_n = lang_len_q;
		next_ofs_n = next_ofs_q;
		count_n    = count_q;
		len_hi_n   = len_hi_q;
		if (pos_q >= POS_MAX) begin
			fail_n = 1'b1;
		end else begin
			pos_nxt = pos_q + POS_W'(1);
			if (pos_q == '0) begin
				version_n = data_byte;
			end else if (pos_q == POS_W'(1)) begin
				func_n = data_byte;
			end
			if (version_n == VER_ONE) begin
				if (pos_q == POS_W'(4) && data_byte[2:0] != 3'd0) begin
					fail_n = 1'b1;
				end
				if (pos_q == POS_W'(5) && data_byte != 8'd0) begin
					fail_n = 1'b1;
				end
			end else if (version_n == VER_TWO) begin
				if (pos_q == POS_W'(5) && data_byte[4:0] != 5'd0) begin
					fail_n = 1'b1;
				end
				if (pos_q == POS_W'(6) && data_byte != 8'd0) begin
					fail_n = 1'b1;
				end
				if (pos_q == POS_W'(12)) begin
					lang_len_n = {data_byte, 8'd0};
				end
				if (pos_q == POS_W'(13)) begin
					lang_len_n = {lang_len_q[15:8], data_byte};
					next_ofs_n = V2_HDR_BYTES + OFS_W'({lang_len_q[15:8], data_byte});
				end
				if (func_q == FUNC_SRV_REQ && pos_ext >= V2_HDR_BYTES
						&& count_q < CNT_MAX) begin
					if (pos_ext == next_ofs_q) begin
						len_hi_n = data_byte;
					end else if (pos_ext == next_ofs_q + OFS_W'(1)) begin
						next_ofs_n = pos_ext + OFS_W'(1) + OFS_W'({len_hi_q, data_byte});
						count_n    = count_q + CNT_W'(1);
					end
				end
			end
		end
	end

	always_comb begin
		hdr_nxt.version      = version_n;
		hdr_nxt.func         = func_n;
		hdr_nxt.fail         = fail_n;
		hdr_nxt.lang_len     = lang_len_n;
		hdr_nxt.next_ofs     = next_ofs_n;
		hdr_nxt.strings_done = (count_n == CNT_MAX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			version_q  <= '0;
			func_q     <= '0;
			fail_q     <= 1'b0;
			lang_len_q <= '0;
			next_ofs_q <= '0;
			count_q    <= '0;
			len_hi_q   <= '0;
		end else if (take) begin
			if (last_byte) begin
				pos_q      <= '0;
				version_q  <= '0;
				func_q     <= '0;
				fail_q     <= 1'b0;
				lang_len_q <= '0;
				next_ofs_q <= '0;
				count_q    <= '0;
				len_hi_q   <= '0;
			end else begin
				pos_q      <= pos_nxt;
				version_q  <= version_n;
				func_q     <= func_n;
				fail_q     <= fail_n;
				lang_len_q <= lang_len_n;
				next_ofs_q <= next_ofs_n;
				count_q    <= count_n;
				len_hi_q   <= len_hi_n;
			end
		end
	end

endmodule

// ----- rtl/core/slpc_verdict.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpc_verdict
// Final classification of a packet from its header state and byte count.
// ----------------------------------------------------------------------------
module slpc_verdict import slpc_pkg::*; #(
	parameter int unsigned POS_W = 16
) (
	input  slpc_hdr_t        hdr,
	input  logic [POS_W-1:0] pos,
	input  logic [CFG_W-1:0] min_v1,
	input  logic [CFG_W-1:0] min_v2,
	input  logic [CFG_W-1:0] lang_max,
	output logic             is_match,
	output logic [1:0]       seen_version
);

	logic [OFS_W-1:0] len;
	logic             v1_ok;
	logic             v2_ok;
	logic             req_ok;

	assign len = OFS_W'(pos);

	always_comb begin
		v1_ok = len >= V1_HDR_BYTES && len >= OFS_W'(min_v1)
			&& hdr.func >= 8'd1 && hdr.func <= FUNC_V1_MAX;
		req_ok = hdr.func != FUNC_SRV_REQ || (hdr.strings_done && hdr.next_ofs <= len);
		v2_ok = len >= V2_HDR_BYTES && len >= OFS_W'(min_v2)
			&& hdr.func >= 8'd1 && hdr.func <= FUNC_V2_MAX
			&& hdr.lang_len != 16'd0 && hdr.lang_len <= 16'(lang_max)
			&& V2_HDR_BYTES + OFS_W'(hdr.lang_len) <= len && req_ok;
		seen_version = SEEN_NONE;
		if (!hdr.fail) begin
			if (hdr.version == VER_ONE && v1_ok) begin
				seen_version = SEEN_V1;
			end else if (hdr.version == VER_TWO && v2_ok) begin
				seen_version = SEEN_V2;
			end
		end
		is_match = seen_version != SEEN_NONE;
	end

endmodule

// ----- test/slpc_verdict_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpc_verdict_check
// Watches the register port and both streams of the SLP header classifier,
// keeps its own copy of the register and payload state, predicts the verdict
// for every payload, and compares each output word against the oldest
// prediction.
// ----------------------------------------------------------------------------
module slpc_verdict_check import slpc_pkg::*; #(
	parameter int unsigned MAX_PAYLOAD_BYTES = DEF_MAX_PAYLOAD_BYTES,
	parameter int unsigned REQUEST_STRINGS   = DEF_REQUEST_STRINGS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [7:0]        s_tdata,
	input  logic              s_tlast,
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [7:0]        m_tdata,
	output int                errors,
	output int                pending
);

	typedef struct packed {
		logic  is_match;
		seen_t seen;
	} verdict_t;

	verdict_t verdicts_due[$];

	logic [CFG_W-1:0] min_v1;
	logic [CFG_W-1:0] min_v2;
	logic [CFG_W-1:0] lang_max;

	logic [16:0] byte_pos;
	logic [7:0]  ver_byte;
	logic [7:0]  func_byte;
	logic        hdr_bad;
	logic [15:0] lang_len;
	logic [19:0] str_ofs;
	logic [2:0]  str_seen;
	logic [7:0]  len_hi;

	initial begin
		errors = 0;
		pending = 0;
	end

	task automatic flag(input string what);
		errors++;
		if (errors <= 10) begin
			$display("%0t ns verdict check: %s", $realtime, what);
		end
	endtask

	task automatic clear_payload();
		byte_pos = '0;
		ver_byte = '0;
		func_byte = '0;
		hdr_bad = 1'b0;
		lang_len = '0;
		str_ofs = '0;
		str_seen = '0;
		len_hi = '0;
	endtask

	always @(posedge clk or negedge arst_n) begin : classify
		int unsigned p;
		int unsigned len;
		verdict_t v;
		if (!arst_n) begin
			min_v1 = RST_MIN_V1;
			min_v2 = RST_MIN_V2;
			lang_max = RST_LANG_MAX;
			clear_payload();
			verdicts_due.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MIN_V1: begin
						min_v1 = cfg_data;
					end
					CFG_MIN_V2: begin
						min_v2 = cfg_data;
					end
					CFG_LANG_MAX: begin
						lang_max = cfg_data;
					end
					default: begin
					end
				endcase
			end

			if (s_tvalid && s_tready) begin
				p = byte_pos;
				if (p >= MAX_PAYLOAD_BYTES) begin
					hdr_bad = 1'b1;
				end else begin
					if (p == 0) begin
						ver_byte = s_tdata;
					end else if (p == 1) begin
						func_byte = s_tdata;
					end
					if (ver_byte == VER_ONE) begin
						if (p == 4 && s_tdata[2:0] != 3'd0) hdr_bad = 1'b1;
						if (p == 5 && s_tdata != 8'd0) hdr_bad = 1'b1;
					end else if (ver_byte == VER_TWO) begin
						if (p == 5 && s_tdata[4:0] != 5'd0) hdr_bad = 1'b1;
						if (p == 6 && s_tdata != 8'd0) hdr_bad = 1'b1;
						if (p == 12) lang_len = {s_tdata, 8'h00};
						if (p == 13) begin
							lang_len[7:0] = s_tdata;
							str_ofs = 20'(V2_HDR_BYTES) + 20'(lang_len);
						end
						if (func_byte == FUNC_SRV_REQ && p >= V2_HDR_BYTES &&
								str_seen < REQUEST_STRINGS) begin
							if (p == str_ofs) begin
								len_hi = s_tdata;
							end else if (p == str_ofs + 1) begin
								str_ofs = 20'(p + 1 + {len_hi, s_tdata});
								str_seen = str_seen + 3'd1;
							end
						end
					end
					byte_pos = 17'(p + 1);
				end

				if (s_tlast) begin
					len = byte_pos;
					v = '{is_match: 1'b0, seen: SEEN_NONE};
					if (!hdr_bad && ver_byte == VER_ONE) begin
						if (len >= V1_HDR_BYTES && len >= min_v1 && func_byte >= 8'd1 &&
								func_byte <= FUNC_V1_MAX) begin
							v = '{is_match: 1'b1, seen: SEEN_V1};
						end
					end else if (!hdr_bad && ver_byte == VER_TWO) begin
						if (len >= V2_HDR_BYTES && len >= min_v2 && func_byte >= 8'd1 &&
								func_byte <= FUNC_V2_MAX && lang_len >= 16'd1 &&
								lang_len <= lang_max && V2_HDR_BYTES + lang_len <= len &&
								(func_byte != FUNC_SRV_REQ ||
								(str_seen == REQUEST_STRINGS && str_ofs <= len))) begin
							v = '{is_match: 1'b1, seen: SEEN_V2};
						end
					end
					verdicts_due.push_back(v);
					clear_payload();
				end
			end

			if (m_tvalid && m_tready) begin
				if (verdicts_due.size() == 0) begin
					flag($sformatf("unexpected word %h with no verdict pending", m_tdata));
				end else begin
					v = verdicts_due.pop_front();
					if (m_tdata[0] !== v.is_match || m_tdata[2:1] !== v.seen ||
							m_tdata[7:3] !== 5'd0) begin
						flag($sformatf({"expected match %0b version %0d pad 00, ",
							"got match %0b version %0d pad %h"}, v.is_match, v.seen,
							m_tdata[0], m_tdata[2:1], m_tdata[7:3]));
					end
				end
			end
		end
		pending = verdicts_due.size();
	end

endmodule

// ----- test/slp_header_classifier_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slp_header_classifier_top_test
// Drives payloads into the SLP header classifier: a directed set of version 1,
// version 2 and foreign headers, then random well-formed, damaged and noise
// payloads under several register settings. Both streams idle at random. The
// checker module predicts and compares every verdict; this module reports the
// outcome.
// ----------------------------------------------------------------------------
module slp_header_classifier_top_test;
	import slpc_pkg::*;

	localparam logic [CFG_IW-1:0] CFG_SPARE = 2'd3;
	localparam int unsigned STALL_LIMIT = 4000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic [CFG_W-1:0]  cfg_data = '0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata = '0;
	logic              s_tlast = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [7:0]        m_tdata;

	int          errors;
	int          pending;
	logic        word_taken = 1'b0;
	bit          calm = 1'b0;
	int unsigned sink_hold = 0;
	int unsigned idle_cycles = 0;
	int unsigned sent_words = 0;

	logic [7:0] cur_min_v1 = RST_MIN_V1;
	logic [7:0] cur_min_v2 = RST_MIN_V2;
	logic [7:0] cur_lang_max = RST_LANG_MAX;
	logic [7:0] pkt[$];

	slp_header_classifier_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	slpc_verdict_check i_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.errors(errors),
		.pending(pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		word_taken <= s_tvalid && s_tready;
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	always @(negedge clk) begin
		if (calm) begin
			m_tready <= 1'b1;
			sink_hold <= 0;
		end else if (sink_hold != 0) begin
			sink_hold <= sink_hold - 1;
		end else if (m_tready) begin
			m_tready <= 1'b0;
			sink_hold <= pick_gap();
		end else begin
			m_tready <= 1'b1;
			sink_hold <= $urandom_range(0, 40);
		end
	end

	task automatic send_pkt();
		int unsigned gap;
		for (int i = 0; i < pkt.size(); i++) begin
			gap = pick_gap();
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata <= pkt[i];
			s_tlast <= (i == pkt.size() - 1);
			@(negedge clk);
			while (!word_taken) @(negedge clk);
			sent_words++;
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IW-1:0] index, input logic [7:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input logic [7:0] v1, input logic [7:0] v2,
			input logic [7:0] lm);
		drain();
		write_reg(CFG_MIN_V1, v1);
		write_reg(CFG_MIN_V2, v2);
		write_reg(CFG_LANG_MAX, lm);
		cur_min_v1 = v1;
		cur_min_v2 = v2;
		cur_lang_max = lm;
	endtask

	task automatic grow_to(input int unsigned goal);
		while (pkt.size() < goal) pkt.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic trim_to(input int unsigned goal);
		while (pkt.size() > goal) void'(pkt.pop_back());
	endtask

	task automatic build_noise(input int unsigned len, input logic [7:0] first);
		pkt = {};
		grow_to(len);
		pkt[0] = first;
	endtask

	task automatic build_v1(input int unsigned len, input logic [7:0] fn);
		pkt = {};
		grow_to(len);
		pkt[0] = VER_ONE;
		if (len > 1) pkt[1] = fn;
		if (len > 4) pkt[4] = pkt[4] & 8'hf8;
		if (len > 5) pkt[5] = 8'h00;
	endtask

	// A negative string length asks for random request string lengths.
	task automatic build_v2(input logic [7:0] fn, input logic [15:0] lang,
			input int str_len);
		int unsigned n;
		pkt = {};
		grow_to(14);
		pkt[0] = VER_TWO;
		pkt[1] = fn;
		pkt[5] = pkt[5] & 8'he0;
		pkt[6] = 8'h00;
		pkt[12] = lang[15:8];
		pkt[13] = lang[7:0];
		grow_to(pkt.size() + (lang > 40 ? 40 : lang));
		if (fn == FUNC_SRV_REQ) begin
			repeat (DEF_REQUEST_STRINGS) begin
				if (str_len >= 0) begin
					n = str_len;
				end else if ($urandom_range(0, 19) == 0) begin
					n = $urandom_range(0, 65535);
				end else begin
					n = $urandom_range(0, 6);
				end
				pkt.push_back(n[15:8]);
				pkt.push_back(n[7:0]);
				grow_to(pkt.size() + (n > 8 ? 8 : n));
			end
		end
	endtask

	task automatic pad_near(input int unsigned min_len);
		int unsigned goal;
		goal = min_len + $urandom_range(0, 8);
		goal = goal > 3 ? goal - 3 : 1;
		if ($urandom_range(0, 3) == 0) goal = pkt.size() + $urandom_range(0, 3);
		grow_to(goal);
	endtask

	task automatic random_payload();
		int unsigned r;
		int unsigned lo;
		int unsigned i;
		logic [15:0] lang;
		r = $urandom_range(0, 9);
		if (r < 8) begin
			lang = 16'($urandom_range(1, cur_lang_max > 10 ? 10 : cur_lang_max));
		end else if (r == 8) begin
			case ($urandom_range(0, 2))
				0: lang = 16'd0;
				1: lang = 16'(cur_lang_max);
				default: lang = cur_lang_max + 16'd1;
			endcase
		end else begin
			lang = 16'($urandom_range(0, 65535));
		end
		lo = cur_min_v1 > 4 ? cur_min_v1 - 4 : 1;

		r = $urandom_range(0, 99);
		if (r < 35) begin
			build_v2(FUNC_SRV_REQ, lang, -1);
			pad_near(cur_min_v2);
		end else if (r < 55) begin
			build_v2(8'($urandom_range(2, FUNC_V2_MAX)), lang, -1);
			pad_near(cur_min_v2);
		end else if (r < 75) begin
			build_v1($urandom_range(lo, cur_min_v1 + 6),
				8'($urandom_range(1, FUNC_V1_MAX)));
		end else if (r < 85) begin
			build_noise($urandom_range(1, 30), 8'($urandom_range(0, 255)));
		end else if (r < 92) begin
			build_v1($urandom_range(lo, cur_min_v1 + 6),
				$urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(FUNC_V1_MAX + 1, 255)));
		end else begin
			build_v2($urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(FUNC_V2_MAX + 1, 255)),
				lang, -1);
			pad_near(cur_min_v2);
		end

		if ($urandom_range(0, 3) == 0) begin
			case ($urandom_range(0, 2))
				0: begin
					i = $urandom_range(0, pkt.size() > 16 ? 15 : pkt.size() - 1);
					pkt[i] = pkt[i] ^ (8'd1 << $urandom_range(0, 7));
				end
				1: trim_to($urandom_range(1, pkt.size()));
				default: grow_to(pkt.size() + $urandom_range(1, 4));
			endcase
		end
		send_pkt();
	endtask

	task automatic run_phase(input bit quiet, input int unsigned words);
		int unsigned start;
		calm = quiet;
		start = sent_words;
		while (sent_words - start < words) begin
			random_payload();
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Register defaults after reset.
		build_v1(12, 8'd1);
		send_pkt();
		build_v1(11, FUNC_V1_MAX);
		send_pkt();
		build_v1(12, FUNC_V1_MAX);
		send_pkt();
		build_v1(12, 8'd0);
		send_pkt();
		build_v1(12, FUNC_V1_MAX + 8'd1);
		send_pkt();
		build_v1(12, 8'd5);
		pkt[4] = 8'h04;
		send_pkt();
		build_v1(12, 8'd5);
		pkt[5] = 8'h01;
		send_pkt();
		build_v1(14, 8'd5);
		pkt[4] = 8'hf8;
		send_pkt();
		build_v2(8'd2, 16'd1, 0);
		grow_to(24);
		send_pkt();
		build_v2(FUNC_V2_MAX, 16'd8, 0);
		grow_to(30);
		send_pkt();
		build_v2(FUNC_V2_MAX + 8'd1, 16'd2, 0);
		grow_to(24);
		send_pkt();
		build_v2(8'd0, 16'd2, 0);
		grow_to(24);
		send_pkt();
		build_v2(8'd3, 16'd2, 0);
		pkt[5] = 8'h10;
		grow_to(24);
		send_pkt();
		build_v2(8'd3, 16'd2, 0);
		pkt[6] = 8'h01;
		grow_to(24);
		send_pkt();
		build_v2(8'd3, 16'd2, 0);
		pkt[5] = 8'he0;
		grow_to(24);
		send_pkt();
		build_v2(8'd4, 16'd0, 0);
		grow_to(24);
		send_pkt();
		build_v2(8'd4, 16'd9, 0);
		grow_to(30);
		send_pkt();
		build_v2(FUNC_SRV_REQ, 16'd2, 0);
		send_pkt();
		build_v2(FUNC_SRV_REQ, 16'd2, 0);
		trim_to(25);
		send_pkt();
		build_noise(20, 8'h00);
		send_pkt();
		build_noise(20, 8'h03);
		send_pkt();
		build_noise(1, 8'hff);
		send_pkt();

		// Smallest minimums, so that only the fixed header sizes apply.
		drain();
		write_reg(CFG_SPARE, 8'hff);
		set_config(8'd1, 8'd1, 8'd1);
		build_v1(5, 8'd3);
		send_pkt();
		build_v1(6, 8'd3);
		send_pkt();
		build_v2(8'd2, 16'd1, 0);
		trim_to(13);
		send_pkt();
		build_v2(8'd2, 16'd1, 0);
		send_pkt();
		run_phase(1'b0, 200);

		set_config(8'd255, 8'd255, 8'd255);
		run_phase(1'b0, 200);
		set_config(RST_MIN_V1, RST_MIN_V2, RST_LANG_MAX);
		run_phase(1'b1, 200);
		set_config(8'($urandom_range(1, 40)), 8'($urandom_range(1, 40)),
			8'($urandom_range(1, 12)));
		run_phase(1'b0, 200);
		set_config(8'd6, 8'd14, 8'd255);
		run_phase(1'b0, 200);
		set_config(8'($urandom_range(1, 255)), 8'($urandom_range(1, 60)),
			8'($urandom_range(1, 255)));
		run_phase(1'b0, 200);

		drain();
		repeat (4) @(negedge clk);
		if (errors == 0 && pending == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
